[src/lpid_pkg.sv]
// Shared widths, types and register indexes of the two-axis leaky PID regulator.
package lpid_pkg;

  localparam int DATA_W     = 32;
  localparam int DT_W       = 16;
  localparam int LEAK_W     = 17;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 8;
  localparam int LEAK_SHIFT = 16;

  localparam int DIG_W        = 4;
  localparam int GAIN_DIGITS  = DATA_W / DIG_W;
  localparam int SHORT_DIGITS = (LEAK_W + DIG_W) / DIG_W;
  localparam int DIG_CNT_W    = $clog2(GAIN_DIGITS);
  localparam int DIV_CNT_W    = $clog2(DATA_W);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic        [DT_W-1:0]   dt_t;
  typedef logic        [LEAK_W-1:0] leak_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic    [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam leak_t ONE_Q16  = leak_t'(65536);
  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam cfg_idx_t REG_GAIN_PROP  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_GAIN_INTEG = cfg_idx_t'(1);
  localparam cfg_idx_t REG_GAIN_DERIV = cfg_idx_t'(2);
  localparam cfg_idx_t REG_LEAK_RATE  = cfg_idx_t'(3);

endpackage

[src/lpid_in_if.sv]
// Input channel of the leaky PID regulator: measured and reference points plus elapsed time.
interface lpid_in_if;
  logic                valid;
  logic                ready;
  lpid_pkg::data_t     meas_x;
  lpid_pkg::data_t     meas_y;
  lpid_pkg::data_t     ref_x;
  lpid_pkg::data_t     ref_y;
  lpid_pkg::dt_t       dt;

  modport source (output valid, output meas_x, output meas_y, output ref_x, output ref_y,
                  output dt, input ready);
  modport sink   (input valid, input meas_x, input meas_y, input ref_x, input ref_y,
                  input dt, output ready);
endinterface

[src/lpid_out_if.sv]
// Result channel of the leaky PID regulator: control offsets and saturation flag.
interface lpid_out_if;
  logic            valid;
  logic            ready;
  lpid_pkg::data_t offset_x;
  lpid_pkg::data_t offset_y;
  logic            sat_flag;

  modport source (output valid, output offset_x, output offset_y, output sat_flag,
                  input ready);
  modport sink   (input valid, input offset_x, input offset_y, input sat_flag,
                  output ready);
endinterface

[src/lpid_cfg_if.sv]
// Configuration write channel of the leaky PID regulator.
interface lpid_cfg_if;
  logic                 valid;
  logic                 ready;
  lpid_pkg::cfg_idx_t   index;
  lpid_pkg::data_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/leaky_pid_two_axis.sv]
// Two-axis PID regulator with leaky integrator, built on a digit-serial multiplier and divider.
//
// Each input beat carries a measured and a reference point for x and y plus the elapsed time;
// one result beat follows with both control offsets and a flag that is set when any error,
// integral, derivative or output saturated. Axes are handled one after the other. Per axis,
// five products go through one shared multiplier that consumes four multiplier bits a cycle
// (two products of five digits, three of eight), each with a setup and a fold step; the
// 32-step restoring divider for the derivative runs beside the first four products. An item
// is taken only once the previous one is finished, but the output register lets it enter
// while a finished result still waits. Configuration writes are always accepted and take
// effect at once; no clearing pass follows reset.
module leaky_pid_two_axis #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lpid_in_if.sink    in_ch,
  lpid_out_if.source out_ch,
  lpid_cfg_if.sink   cfg_ch
);

  localparam int DATA_W = lpid_pkg::DATA_W;
  localparam int DT_W   = lpid_pkg::DT_W;
  localparam int DIG_W  = lpid_pkg::DIG_W;
  localparam int ACC_W  = lpid_pkg::ACC_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ERR   = 4'd1;
  localparam logic [3:0] ST_DIFF  = 4'd2;
  localparam logic [3:0] ST_LOAD  = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_POST  = 4'd5;
  localparam logic [3:0] ST_DERIV = 4'd6;
  localparam logic [3:0] ST_AXIS  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  localparam logic [2:0] OP_LEAK = 3'd0;
  localparam logic [2:0] OP_DT   = 3'd1;
  localparam logic [2:0] OP_GP   = 3'd2;
  localparam logic [2:0] OP_GI   = 3'd3;
  localparam logic [2:0] OP_GD   = 3'd4;

  typedef struct packed {
    logic            hit;
    lpid_pkg::data_t val;
  } sat_t;

  function automatic sat_t sat32(input lpid_pkg::acc_t v);
    sat_t r;
    r.hit = (v[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){v[ACC_W-1]}});
    if (r.hit) begin
      r.val = v[ACC_W-1] ? lpid_pkg::DATA_MIN : lpid_pkg::DATA_MAX;
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // control
  logic [3:0] state_r, state_nxt;
  logic       ax_r;
  logic [2:0] op_r;
  logic       flag_r;
  logic       out_valid_r;

  // configuration
  lpid_pkg::data_t gain_prop_r, gain_integ_r, gain_deriv_r;
  lpid_pkg::leak_t leak_rate_r;

  // per-axis state
  lpid_pkg::data_t integ_r [2];
  lpid_pkg::data_t prev_err_r [2];

  // latched item and working values
  lpid_pkg::data_t        meas_r [2];
  lpid_pkg::data_t        ref_r [2];
  lpid_pkg::dt_t          dt_r;
  lpid_pkg::data_t        err_r;
  logic signed [DATA_W:0] diff_r;
  lpid_pkg::data_t        deriv_r;
  lpid_pkg::data_t        ox_r, oy_r;

  // multiplier
  lpid_pkg::acc_t                 acc_r, sum_r, mul_a_r;
  logic [DATA_W-1:0]              mul_b_r;
  logic [lpid_pkg::DIG_CNT_W-1:0] dig_cnt_r, dig_last_r;

  // divider
  logic [DATA_W-1:0]              div_q_r;
  lpid_pkg::dt_t                  div_rem_r, div_rem_nxt;
  logic [lpid_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic                           div_busy_r, div_ovf_r, div_neg_r;

  // output register
  lpid_pkg::data_t out_x_r, out_y_r;
  logic            out_sat_r;

  logic                           in_acc, out_acc, out_load;
  logic signed [DATA_W:0]         err_wide, diff_wide;
  sat_t                           err_sat, integ_sat, res_sat;
  lpid_pkg::leak_t                leak_eff, one_minus;
  lpid_pkg::data_t                ld_a;
  logic [DATA_W-1:0]              ld_b;
  logic [lpid_pkg::DIG_CNT_W-1:0] ld_last;
  logic                           dig_is_last;
  logic signed [DIG_W:0]          digit;
  lpid_pkg::acc_t                 pp, term;
  logic                           div_start, div_ovf_start, div_run;
  logic [DATA_W-1:0]              div_mag;
  logic [DT_W:0]                  div_trial, div_sub;
  logic                           div_take;
  lpid_pkg::data_t                deriv_val;
  logic                           deriv_hit;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_acc         = out_valid_r && out_ch.ready;
  assign out_load        = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.offset_x = out_x_r;
  assign out_ch.offset_y = out_y_r;
  assign out_ch.sat_flag = out_sat_r;

  assign err_wide  = (DATA_W+1)'(meas_r[ax_r]) - (DATA_W+1)'(ref_r[ax_r]);
  assign err_sat   = sat32(ACC_W'(err_wide));
  assign diff_wide = (DATA_W+1)'(err_r) - (DATA_W+1)'(prev_err_r[ax_r]);
  assign integ_sat = sat32(acc_r >>> lpid_pkg::LEAK_SHIFT);
  assign res_sat   = sat32(sum_r);
  assign term      = acc_r >>> FRAC_BITS;

  assign leak_eff  = (leak_rate_r > lpid_pkg::ONE_Q16) ? lpid_pkg::ONE_Q16 : leak_rate_r;
  assign one_minus = lpid_pkg::ONE_Q16 - leak_eff;

  always_comb begin
    ld_a    = deriv_r;
    ld_b    = gain_deriv_r;
    ld_last = lpid_pkg::DIG_CNT_W'(lpid_pkg::GAIN_DIGITS - 1);
    case (op_r)
      OP_LEAK: begin
        ld_a    = integ_r[ax_r];
        ld_b    = DATA_W'(one_minus);
        ld_last = lpid_pkg::DIG_CNT_W'(lpid_pkg::SHORT_DIGITS - 1);
      end
      OP_DT: begin
        ld_a    = err_r;
        ld_b    = DATA_W'(dt_r);
        ld_last = lpid_pkg::DIG_CNT_W'(lpid_pkg::SHORT_DIGITS - 1);
      end
      OP_GP: begin
        ld_a = err_r;
        ld_b = gain_prop_r;
      end
      OP_GI: begin
        ld_a = integ_r[ax_r];
        ld_b = gain_integ_r;
      end
      OP_GD: begin
        ld_a = deriv_r;
        ld_b = gain_deriv_r;
      end
      default: begin
        ld_a = deriv_r;
        ld_b = gain_deriv_r;
      end
    endcase
  end

  // top digit of the multiplier operand carries its sign
  assign dig_is_last = (dig_cnt_r == dig_last_r);
  assign digit = dig_is_last ? {mul_b_r[DIG_W-1], mul_b_r[DIG_W-1:0]}
                             : {1'b0, mul_b_r[DIG_W-1:0]};
  assign pp    = mul_a_r * digit;

  // derivative: |diff| * 2^16 / dt, high half checked for overflow up front
  assign div_start     = (state_r == ST_LOAD) && (op_r == OP_LEAK);
  assign div_mag       = diff_r[DATA_W] ? DATA_W'(-diff_r) : diff_r[DATA_W-1:0];
  assign div_ovf_start = (diff_r != '0) && (div_mag[DATA_W-1:DATA_W-DT_W] >= dt_r);
  assign div_run       = (diff_r != '0) && !div_ovf_start;
  assign div_trial     = {div_rem_r, div_q_r[DATA_W-1]};
  assign div_take      = (div_trial >= {1'b0, dt_r});
  assign div_sub       = div_trial - {1'b0, dt_r};
  assign div_rem_nxt   = div_take ? div_sub[DT_W-1:0] : div_trial[DT_W-1:0];

  always_comb begin
    deriv_hit = 1'b0;
    deriv_val = div_q_r;
    if (div_ovf_r) begin
      deriv_hit = 1'b1;
      deriv_val = div_neg_r ? lpid_pkg::DATA_MIN : lpid_pkg::DATA_MAX;
    end else if (div_neg_r) begin
      if (div_q_r > lpid_pkg::DATA_MIN) begin
        deriv_hit = 1'b1;
        deriv_val = lpid_pkg::DATA_MIN;
      end else begin
        deriv_val = ~div_q_r + 1'b1;
      end
    end else if (div_q_r[DATA_W-1]) begin
      deriv_hit = 1'b1;
      deriv_val = lpid_pkg::DATA_MAX;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL:   if (dig_is_last) state_nxt = ST_POST;
      ST_POST: begin
        case (op_r)
          OP_LEAK: state_nxt = ST_LOAD;
          OP_DT:   state_nxt = ST_LOAD;
          OP_GP:   state_nxt = ST_LOAD;
          OP_GI:   state_nxt = ST_DERIV;
          OP_GD:   state_nxt = ST_AXIS;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DERIV: if (!div_busy_r) state_nxt = ST_LOAD;
      ST_AXIS:  state_nxt = ax_r ? ST_FIN : ST_ERR;
      ST_FIN:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ax_r          <= 1'b0;
      op_r          <= OP_LEAK;
      flag_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      dig_cnt_r     <= '0;
      dig_last_r    <= '0;
      div_cnt_r     <= '0;
      div_busy_r    <= 1'b0;
      gain_prop_r   <= '0;
      gain_integ_r  <= '0;
      gain_deriv_r  <= '0;
      leak_rate_r   <= '0;
      integ_r[0]    <= '0;
      integ_r[1]    <= '0;
      prev_err_r[0] <= '0;
      prev_err_r[1] <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          lpid_pkg::REG_GAIN_PROP:  gain_prop_r  <= cfg_ch.data;
          lpid_pkg::REG_GAIN_INTEG: gain_integ_r <= cfg_ch.data;
          lpid_pkg::REG_GAIN_DERIV: gain_deriv_r <= cfg_ch.data;
          lpid_pkg::REG_LEAK_RATE:  leak_rate_r  <= cfg_ch.data[lpid_pkg::LEAK_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            ax_r   <= 1'b0;
            flag_r <= 1'b0;
          end
        end
        ST_ERR:  flag_r <= flag_r | err_sat.hit;
        ST_DIFF: begin
          prev_err_r[ax_r] <= err_r;
          op_r             <= OP_LEAK;
        end
        ST_LOAD: begin
          dig_cnt_r  <= '0;
          dig_last_r <= ld_last;
        end
        ST_MUL:  dig_cnt_r <= dig_cnt_r + 1'b1;
        ST_POST: begin
          case (op_r)
            OP_LEAK: op_r <= OP_DT;
            OP_DT: begin
              op_r          <= OP_GP;
              integ_r[ax_r] <= integ_sat.val;
              flag_r        <= flag_r | integ_sat.hit;
            end
            OP_GP:   op_r <= OP_GI;
            OP_GI:   op_r <= OP_GD;
            default: ;
          endcase
        end
        ST_DERIV: if (!div_busy_r) flag_r <= flag_r | deriv_hit;
        ST_AXIS: begin
          flag_r <= flag_r | res_sat.hit;
          ax_r   <= 1'b1;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end

      if (div_start) begin
        div_busy_r <= div_run;
        div_cnt_r  <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_cnt_r == lpid_pkg::DIV_CNT_W'(DATA_W - 1)) begin
          div_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r[0] <= in_ch.meas_x;
      meas_r[1] <= in_ch.meas_y;
      ref_r[0]  <= in_ch.ref_x;
      ref_r[1]  <= in_ch.ref_y;
      dt_r      <= in_ch.dt;
    end

    case (state_r)
      ST_ERR:  err_r  <= err_sat.val;
      ST_DIFF: diff_r <= diff_wide;
      ST_LOAD: begin
        mul_a_r <= ACC_W'(ld_a);
        mul_b_r <= ld_b;
        if (op_r != OP_DT) acc_r <= '0;
      end
      ST_MUL: begin
        acc_r   <= acc_r + pp;
        mul_a_r <= mul_a_r <<< DIG_W;
        mul_b_r <= mul_b_r >> DIG_W;
      end
      ST_POST: begin
        case (op_r)
          OP_DT:   sum_r <= '0;
          OP_GP:   sum_r <= sum_r + term;
          OP_GI:   sum_r <= sum_r + term;
          OP_GD:   sum_r <= sum_r + term;
          default: ;
        endcase
      end
      ST_DERIV: if (!div_busy_r) deriv_r <= deriv_val;
      ST_AXIS: begin
        if (ax_r) begin
          oy_r <= res_sat.val;
        end else begin
          ox_r <= res_sat.val;
        end
      end
      default: ;
    endcase

    if (div_start) begin
      div_q_r   <= {div_mag[DT_W-1:0], {(DATA_W-DT_W){1'b0}}};
      div_rem_r <= div_mag[DATA_W-1:DATA_W-DT_W];
      div_ovf_r <= div_ovf_start;
      div_neg_r <= diff_r[DATA_W];
    end else if (div_busy_r) begin
      div_q_r   <= {div_q_r[DATA_W-2:0], div_take};
      div_rem_r <= div_rem_nxt;
    end

    if (out_load) begin
      out_x_r   <= ox_r;
      out_y_r   <= oy_r;
      out_sat_r <= flag_r;
    end
  end

endmodule

[src/lpid_chk.sv]
// Port-level assertions for the leaky PID regulator, bound to its top level.
module lpid_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input lpid_pkg::data_t offset_x,
  input lpid_pkg::data_t offset_y,
  input logic            sat_flag
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(offset_x) && $stable(offset_y)
                                && $stable(sat_flag))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken while an item is in work");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without a pending item");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two items pending");

endmodule

bind leaky_pid_two_axis lpid_chk u_lpid_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .offset_x  (out_ch.offset_x),
  .offset_y  (out_ch.offset_y),
  .sat_flag  (out_ch.sat_flag)
);

[dv/leaky_pid_two_axis_tb.sv]
// Self-checking testbench for leaky_pid_two_axis: directed corners, then random beats under varied back-pressure.
module leaky_pid_two_axis_tb;
  import lpid_pkg::*;

  localparam int FRAC         = 16;
  localparam int PHASES       = 6;
  localparam int PHASE_BEATS  = 188;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    data_t meas_x;
    data_t meas_y;
    data_t ref_x;
    data_t ref_y;
    dt_t   dt;
  } pid_sample_t;

  typedef struct packed {
    data_t offset_x;
    data_t offset_y;
    logic  sat_flag;
  } pid_offsets_t;

  class offset_checker;
    pid_offsets_t pending_offsets[$];
    longint gain_p, gain_i, gain_d;
    leak_t  leak;
    longint integ_acc[2];
    longint prev_err[2];
    bit     sat_seen;
    int     errors;
    int     checked;

    function new();
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      leak = '0;
      integ_acc = '{0, 0};
      prev_err = '{0, 0};
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, data_t value);
      case (idx)
        REG_GAIN_PROP:  gain_p = longint'(value);
        REG_GAIN_INTEG: gain_i = longint'(value);
        REG_GAIN_DERIV: gain_d = longint'(value);
        REG_LEAK_RATE:  leak = value[LEAK_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(DATA_MAX)) begin
        sat_seen = 1'b1;
        return longint'(DATA_MAX);
      end
      if (v < longint'(DATA_MIN)) begin
        sat_seen = 1'b1;
        return longint'(DATA_MIN);
      end
      return v;
    endfunction

    function longint axis_offset(int axis, data_t meas, data_t target, dt_t dt);
      longint lk, err, acc, integ, diff, deriv, total;
      lk = (leak > ONE_Q16) ? longint'(ONE_Q16) : longint'(leak);
      err = clamp32(longint'(meas) - longint'(target));
      acc = (65536 - lk) * integ_acc[axis] + err * longint'(dt);
      integ = clamp32(acc >>> LEAK_SHIFT);
      diff = err - prev_err[axis];
      if (dt == '0) begin
        if (diff == 0) begin
          deriv = 0;
        end else begin
          sat_seen = 1'b1;
          deriv = (diff > 0) ? longint'(DATA_MAX) : longint'(DATA_MIN);
        end
      end else begin
        deriv = clamp32((diff * 65536) / longint'(dt));
      end
      integ_acc[axis] = integ;
      prev_err[axis] = err;
      total = ((gain_p * err) >>> FRAC) + ((gain_i * integ) >>> FRAC)
            + ((gain_d * deriv) >>> FRAC);
      return clamp32(total);
    endfunction

    function void note_sample(pid_sample_t s);
      pid_offsets_t o;
      sat_seen = 1'b0;
      o.offset_x = data_t'(axis_offset(0, s.meas_x, s.ref_x, s.dt));
      o.offset_y = data_t'(axis_offset(1, s.meas_y, s.ref_y, s.dt));
      o.sat_flag = sat_seen;
      pending_offsets.push_back(o);
    endfunction

    function void check_offsets(data_t ox, data_t oy, logic sat);
      pid_offsets_t e;
      if (pending_offsets.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat x=%0d y=%0d sat=%b", $time, ox, oy, sat);
        return;
      end
      e = pending_offsets.pop_front();
      checked++;
      if (ox !== e.offset_x) begin
        errors++;
        $display("%0t: offset_x expected %0d, got %0d", $time, e.offset_x, ox);
      end
      if (oy !== e.offset_y) begin
        errors++;
        $display("%0t: offset_y expected %0d, got %0d", $time, e.offset_y, oy);
      end
      if (sat !== e.sat_flag) begin
        errors++;
        $display("%0t: sat_flag expected %b, got %b", $time, e.sat_flag, sat);
      end
    endfunction

    function int pending();
      return pending_offsets.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lpid_in_if  in_ch();
  lpid_out_if out_ch();
  lpid_cfg_if cfg_ch();

  leaky_pid_two_axis #(.FRAC_BITS(FRAC)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  offset_checker sb = new();
  int in_idle_pct  = 37;
  int out_idle_pct = 77;
  int hold_left    = 0;
  int beats_sent   = 0;
  int cfg_writes   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("leaky_pid_two_axis test failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever @(negedge clk) begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_offsets(out_ch.offset_x, out_ch.offset_y, out_ch.sat_flag);
  end

  task automatic cfg_write(cfg_idx_t idx, data_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, value);
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(pid_sample_t s);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.meas_x <= s.meas_x;
    in_ch.meas_y <= s.meas_y;
    in_ch.ref_x  <= s.ref_x;
    in_ch.ref_y  <= s.ref_y;
    in_ch.dt     <= s.dt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_sample(s);
    beats_sent++;
    @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge with every result taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic pid_sample_t mk(data_t mx, data_t my, data_t rx, data_t ry, dt_t dt);
    pid_sample_t s;
    s.meas_x = mx;
    s.meas_y = my;
    s.ref_x  = rx;
    s.ref_y  = ry;
    s.dt     = dt;
    return s;
  endfunction

  function automatic data_t pick_extreme();
    case ($urandom_range(0, 3))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic data_t random_gain();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return pick_extreme();
    if (m < 3) return data_t'($urandom);
    return data_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  function automatic data_t random_leak();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return data_t'(65536);
      2: return data_t'($urandom_range(65537, 131071));
      3: return data_t'($urandom);
      4: return data_t'($urandom_range(0, 65536));
      default: return data_t'($urandom_range(0, 4096));
    endcase
  endfunction

  function automatic pid_sample_t random_sample();
    pid_sample_t s;
    int m, d;
    m = $urandom_range(0, 99);
    if (m < 55) begin
      // tracking: measured point close to the reference
      s.ref_x  = data_t'($urandom);
      s.ref_y  = data_t'($urandom);
      s.meas_x = s.ref_x + data_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      s.meas_y = s.ref_y + data_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    end else if (m < 75) begin
      s.ref_x  = data_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      s.ref_y  = data_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      s.meas_x = data_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      s.meas_y = data_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    end else if (m < 95) begin
      s.ref_x  = data_t'($urandom);
      s.ref_y  = data_t'($urandom);
      s.meas_x = data_t'($urandom);
      s.meas_y = data_t'($urandom);
    end else begin
      s.ref_x  = pick_extreme();
      s.ref_y  = pick_extreme();
      s.meas_x = pick_extreme();
      s.meas_y = pick_extreme();
    end
    d = $urandom_range(0, 99);
    if (d < 3)
      s.dt = '0;
    else if (d < 10)
      s.dt = '1;
    else if (d < 25)
      s.dt = dt_t'($urandom_range(1, 16));
    else
      s.dt = dt_t'($urandom_range(1, 65535));
    return s;
  endfunction

  task automatic run_directed();
    data_t one;
    one = data_t'(65536);
    cfg_write(REG_GAIN_PROP, one);
    cfg_write(REG_GAIN_INTEG, one);
    cfg_write(REG_GAIN_DERIV, one);
    cfg_write(REG_LEAK_RATE, '0);
    send_sample(mk('0, '0, '0, '0, dt_t'(1)));
    // saturated errors of both signs, then zero time with unchanged error
    send_sample(mk(DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX, '1));
    send_sample(mk(DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX, '0));
    // zero time with a changed error
    send_sample(mk('0, '0, '0, '0, '0));
    send_sample(mk(data_t'(100 << 16), -data_t'(100 << 16), '0, '0, dt_t'(1)));
    send_sample(mk(data_t'(100 << 16), -data_t'(100 << 16), '0, '0, '1));
    send_sample(mk(data_t'(100 << 16), -data_t'(100 << 16), '0, '0, '0));
    send_sample(mk(data_t'(12345), data_t'(-777), data_t'(12345), data_t'(-777), dt_t'(300)));
    send_sample(mk(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN, dt_t'(16'h8000)));
    drain();
    // full leak, extreme gains
    cfg_write(REG_LEAK_RATE, data_t'(65536));
    cfg_write(REG_GAIN_PROP, DATA_MAX);
    cfg_write(REG_GAIN_INTEG, DATA_MIN);
    cfg_write(REG_GAIN_DERIV, '1);
    send_sample(mk(data_t'(3 << 16), data_t'(-5 << 16), '0, '0, dt_t'(16'h4000)));
    send_sample(mk(DATA_MIN, DATA_MAX, '0, '0, '1));
    send_sample(mk('0, '0, '0, '0, dt_t'(1)));
    drain();
    // leak above one with junk upper bits, and writes to unknown registers
    cfg_write(REG_LEAK_RATE, '1);
    cfg_write(cfg_idx_t'(4), data_t'(32'h1234_5678));
    cfg_write(cfg_idx_t'(255), '1);
    cfg_write(REG_GAIN_PROP, DATA_MIN);
    cfg_write(REG_GAIN_INTEG, DATA_MAX);
    cfg_write(REG_GAIN_DERIV, DATA_MIN);
    send_sample(mk(data_t'(1), data_t'(-1), '0, '0, dt_t'(1)));
    send_sample(mk(DATA_MAX, DATA_MAX, DATA_MIN, DATA_MIN, '1));
    send_sample(mk(data_t'(1 << 16), data_t'(-(1 << 16)), '0, '0, '0));
    drain();
    cfg_write(REG_LEAK_RATE, data_t'(70000));
    cfg_write(REG_GAIN_PROP, '0);
    cfg_write(REG_GAIN_INTEG, '0);
    cfg_write(REG_GAIN_DERIV, '0);
    send_sample(mk(DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX, '0));
    drain();
    // partial leak with unit proportional and integral gains and a small derivative gain
    cfg_write(REG_LEAK_RATE, data_t'(32768));
    cfg_write(REG_GAIN_PROP, one);
    cfg_write(REG_GAIN_INTEG, one);
    cfg_write(REG_GAIN_DERIV, data_t'(16));
    repeat (4) send_sample(mk(data_t'(50 << 16), data_t'(-(7 << 16)), '0, '0, dt_t'(16'h2000)));
    send_sample(mk('0, '0, '0, '0, dt_t'(16'h2000)));
    drain();
  endtask

  initial begin
    int directed;
    rst_n = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.meas_x = '0;
    in_ch.meas_y = '0;
    in_ch.ref_x  = '0;
    in_ch.ref_y  = '0;
    in_ch.dt     = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    directed = beats_sent;

    for (int p = 0; p < PHASES; p++) begin
      in_idle_pct  = (p < 2) ? 37 : (p < 4) ? 77 : 0;
      out_idle_pct = (p < 2) ? 77 : (p < 4) ? 37 : 0;
      if (p == PHASES - 1) begin
        cfg_write(REG_GAIN_PROP, DATA_MIN);
        cfg_write(REG_GAIN_INTEG, DATA_MAX);
        cfg_write(REG_GAIN_DERIV, DATA_MIN);
        cfg_write(REG_LEAK_RATE, '0);
      end else begin
        cfg_write(REG_GAIN_PROP, random_gain());
        cfg_write(REG_GAIN_INTEG, random_gain());
        cfg_write(REG_GAIN_DERIV, random_gain());
        cfg_write(REG_LEAK_RATE, random_leak());
      end
      cfg_write(cfg_idx_t'($urandom_range(4, 255)), data_t'($urandom));
      if (p == 4)
        hold_left = HOLD_CYCLES;
      for (int i = 0; i < PHASE_BEATS; i++)
        send_sample(random_sample());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d input beats (%0d directed, rest random over %0d settings), %0d cfg writes.",
             beats_sent, directed, PHASES, cfg_writes);
    $display("Checked %0d result beats under mixed stalls and a %0d-cycle output hold; errors: %0d",
             sb.checked, HOLD_CYCLES, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("leaky_pid_two_axis test passed");
    end else begin
      $display("leaky_pid_two_axis test failed");
    end
    $finish;
  end

endmodule

[leaky_pid_two_axis.f]
src/lpid_pkg.sv
src/lpid_in_if.sv
src/lpid_out_if.sv
src/lpid_cfg_if.sv
src/leaky_pid_two_axis.sv
src/lpid_chk.sv
dv/leaky_pid_two_axis_tb.sv
